/* hw/rtl/tfn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;

    // Default geometry of the datapath
    localparam int COORD_WIDTH_DEF      = 16;
    localparam int NORMAL_FRAC_BITS_DEF = 14;

    // Register stages in the front part, ahead of the queue
    localparam int FRONT_STAGES = 3;

    // Queue between front and back; leaves room for the items still in the front
    // plus the one entry that sits in the queue while a steady stream passes
    localparam int QUEUE_DEPTH = 5;

endpackage
`default_nettype wire

/* hw/rtl/tfn_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfn_front #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_take,
    input  wire logic [COORD_WIDTH-1:0]          i_first_x,
    input  wire logic [COORD_WIDTH-1:0]          i_first_y,
    input  wire logic [COORD_WIDTH-1:0]          i_first_z,
    input  wire logic [COORD_WIDTH-1:0]          i_second_x,
    input  wire logic [COORD_WIDTH-1:0]          i_second_y,
    input  wire logic [COORD_WIDTH-1:0]          i_second_z,
    input  wire logic [COORD_WIDTH-1:0]          i_third_x,
    input  wire logic [COORD_WIDTH-1:0]          i_third_y,
    input  wire logic [COORD_WIDTH-1:0]          i_third_z,
    output logic                                 o_valid,
    output logic signed [2*(COORD_WIDTH+1):0]    o_nx,
    output logic signed [2*(COORD_WIDTH+1):0]    o_ny,
    output logic signed [2*(COORD_WIDTH+1):0]    o_nz,
    output logic                                 o_degenerate
);
    import tfn_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_dx, r_dy, r_dz, r_ex, r_ey, r_ez;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [PW:0]   r_nx, r_ny, r_nz;
    logic                 r_deg;

    // Advance the valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Edge vectors, cross product terms, then the cross product and its class
    always_ff @(posedge i_clk) begin
        r_dx <= {i_first_x[COORD_WIDTH-1], i_first_x} - {i_second_x[COORD_WIDTH-1], i_second_x};
        r_dy <= {i_first_y[COORD_WIDTH-1], i_first_y} - {i_second_y[COORD_WIDTH-1], i_second_y};
        r_dz <= {i_first_z[COORD_WIDTH-1], i_first_z} - {i_second_z[COORD_WIDTH-1], i_second_z};
        r_ex <= {i_second_x[COORD_WIDTH-1], i_second_x} - {i_third_x[COORD_WIDTH-1], i_third_x};
        r_ey <= {i_second_y[COORD_WIDTH-1], i_second_y} - {i_third_y[COORD_WIDTH-1], i_third_y};
        r_ez <= {i_second_z[COORD_WIDTH-1], i_second_z} - {i_third_z[COORD_WIDTH-1], i_third_z};

        r_p0 <= r_dy * r_ez;
        r_p1 <= r_dz * r_ey;
        r_p2 <= r_dz * r_ex;
        r_p3 <= r_dx * r_ez;
        r_p4 <= r_dx * r_ey;
        r_p5 <= r_dy * r_ex;

        r_nx  <= {r_p0[PW-1], r_p0} - {r_p1[PW-1], r_p1};
        r_ny  <= {r_p2[PW-1], r_p2} - {r_p3[PW-1], r_p3};
        r_nz  <= {r_p4[PW-1], r_p4} - {r_p5[PW-1], r_p5};
        r_deg <= (r_p0 == r_p1) && (r_p2 == r_p3) && (r_p4 == r_p5);
    end

    assign o_valid      = r_v3;
    assign o_nx         = r_nx;
    assign o_ny         = r_ny;
    assign o_nz         = r_nz;
    assign o_degenerate = r_deg;

endmodule
`default_nettype wire

/* hw/rtl/tfn_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tfn_pkg::QUEUE_DEPTH,
    parameter int SLACK = tfn_pkg::FRONT_STAGES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    import tfn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_data;
    logic             r_dv;
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CNW-1:0]   r_count, n_count;
    logic             pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Advance the pointers and the fill count
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            r_dv    <= pop_ok;
        end
    end

    // Hold the entries; register the item that leaves
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (pop_ok) begin
            r_data <= r_mem[r_rd];
        end
    end

    assign o_valid = r_dv;
    assign o_data  = r_data;
    assign o_empty = (r_count == '0);
    // Stop the front early enough for the items it still carries
    assign o_full  = (r_count >= CNW'(DEPTH - SLACK));

endmodule
`default_nettype wire

/* hw/rtl/tfn_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfn_back #(
    parameter int NW               = 35,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [NW-1:0]               i_nx,
    input  wire logic signed [NW-1:0]               i_ny,
    input  wire logic signed [NW-1:0]               i_nz,
    input  wire logic                               i_degenerate,
    output logic                                    o_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]      o_normal_z,
    output logic                                    o_degenerate
);
    import tfn_pkg::*;

    localparam int F   = NORMAL_FRAC_BITS;
    localparam int SQW = 2 * NW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW + 2 * F + 2;
    localparam int QW  = F + 1;
    localparam int OW  = F + 2;
    localparam int NS  = F + 1;

    logic signed [NW-1:0] n_in [0:2];
    logic          r_va, r_vb, r_vo;
    logic [NW-1:0] r_mag [0:2];
    logic [SQW-1:0] r_sq [0:2];
    logic [2:0]    r_sgn_a, r_sgn_b;
    logic          r_deg_a, r_deg_b;

    // Per iteration stage: remainder, running q*S, quotient bits
    logic [RW-1:0] r_rem [0:NS][0:2];
    logic [RW-1:0] r_prd [0:NS][0:2];
    logic [QW-1:0] r_q   [0:NS][0:2];
    logic [SW-1:0] r_s   [0:NS];
    logic [2:0]    r_sgn [0:NS];
    logic          r_deg [0:NS];
    logic          r_v   [0:NS];
    logic [OW-1:0] r_out [0:2];
    logic          r_deg_o;

    assign n_in[0] = i_nx;
    assign n_in[1] = i_ny;
    assign n_in[2] = i_nz;

    // Advance the valid marks of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_v[0]  <= 1'b0;
            r_vo    <= 1'b0;
        end else begin
            r_va    <= i_valid;
            r_vb    <= r_va;
            r_v[0]  <= r_vb;
            r_vo    <= r_v[NS];
        end
    end

    // Magnitudes, squares, then the squared length and the starting remainder
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_mag[l]   <= n_in[l][NW-1] ? (~n_in[l] + 1'b1) : n_in[l];
            r_sgn_a[l] <= n_in[l][NW-1];
            r_sq[l]    <= r_mag[l] * r_mag[l];
            r_rem[0][l] <= RW'(r_sq[l]) << (2 * F);
            r_prd[0][l] <= '0;
            r_q[0][l]   <= '0;
        end
        r_deg_a  <= i_degenerate;
        r_sgn_b  <= r_sgn_a;
        r_deg_b  <= r_deg_a;
        r_s[0]   <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
        r_sgn[0] <= r_sgn_b;
        r_deg[0] <= r_deg_b;
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < NS; k++) begin : g_bit
        localparam int B = F - k;
        logic [RW-1:0] delta [0:2];
        logic [2:0]    fits;

        // Growth of q*q*S when bit B is set
        always_comb begin
            for (int l = 0; l < 3; l++) begin
                delta[l] = (r_prd[k][l] << (B + 1)) + (RW'(r_s[k]) << (2 * B));
                fits[l]  = (delta[l] <= r_rem[k][l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                if (fits[l]) begin
                    r_rem[k+1][l] <= r_rem[k][l] - delta[l];
                    r_prd[k+1][l] <= r_prd[k][l] + (RW'(r_s[k]) << B);
                    r_q[k+1][l]   <= r_q[k][l] | (QW'(1) << B);
                end else begin
                    r_rem[k+1][l] <= r_rem[k][l];
                    r_prd[k+1][l] <= r_prd[k][l];
                    r_q[k+1][l]   <= r_q[k][l];
                end
            end
            r_s[k+1]   <= r_s[k];
            r_sgn[k+1] <= r_sgn[k];
            r_deg[k+1] <= r_deg[k];
        end
    end

    // Apply the sign; drop the normal of a degenerate triangle
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (r_deg[NS]) begin
                r_out[l] <= '0;
            end else if (r_sgn[NS][l]) begin
                r_out[l] <= ~{1'b0, r_q[NS][l]} + 1'b1;
            end else begin
                r_out[l] <= {1'b0, r_q[NS][l]};
            end
        end
        r_deg_o <= r_deg[NS];
    end

    assign o_valid      = r_vo;
    assign o_normal_x   = r_out[0];
    assign o_normal_y   = r_out[1];
    assign o_normal_z   = r_out[2];
    assign o_degenerate = r_deg_o;

endmodule
`default_nettype wire

/* hw/rtl/triangle_face_normal.sv */
`timescale 1ns / 1ps
`default_nettype none
// Unit face normal of a triangle.
// Input: the three vertices as signed Q8.8 coordinates, taken when start is
// high and busy is low. The normal (a-b) x (b-c) is scaled to unit length as
// signed Q1.14 components, truncated toward zero. A triangle with a zero cross
// product gives o_degenerate high and a zero normal.
// Result: one per item, shown for exactly one cycle with o_strobe high; the
// receiver cannot hold it off, and nothing downstream ever waits.
// Path from start to o_strobe: three front stages (edges, products, cross
// product), the queue and its read register, then the back part: magnitude,
// squares, length sum, one stage per quotient bit of the exact normalising
// divide, and the output register.
// Throughput: one item per cycle while busy is low; the back pipeline never stalls, so the queue
// drains as fast as it fills and busy stays low in normal use.
// Reset: synchronous, active low; clears every valid mark and the queue, so no
// result appears until an item has gone through the whole pipeline.
module triangle_face_normal #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [COORD_WIDTH-1:0]        i_first_x,
    input  wire logic [COORD_WIDTH-1:0]        i_first_y,
    input  wire logic [COORD_WIDTH-1:0]        i_first_z,
    input  wire logic [COORD_WIDTH-1:0]        i_second_x,
    input  wire logic [COORD_WIDTH-1:0]        i_second_y,
    input  wire logic [COORD_WIDTH-1:0]        i_second_z,
    input  wire logic [COORD_WIDTH-1:0]        i_third_x,
    input  wire logic [COORD_WIDTH-1:0]        i_third_y,
    input  wire logic [COORD_WIDTH-1:0]        i_third_z,
    output logic                               o_strobe,
    output logic [NORMAL_FRAC_BITS+1:0]        o_normal_x,
    output logic [NORMAL_FRAC_BITS+1:0]        o_normal_y,
    output logic [NORMAL_FRAC_BITS+1:0]        o_normal_z,
    output logic                               o_degenerate
);
    import tfn_pkg::*;

    localparam int NW = 2 * (COORD_WIDTH + 1) + 1;
    localparam int QDW = 3 * NW + 1;

    logic              take;
    logic              f_valid, f_deg;
    logic signed [NW-1:0] f_nx, f_ny, f_nz;
    logic [QDW-1:0]    q_out;
    logic              q_valid, q_empty, q_full;

    assign take = start && !busy;
    assign busy = q_full;

    tfn_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_first_z    (i_first_z),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_second_z   (i_second_z),
        .i_third_x    (i_third_x),
        .i_third_y    (i_third_y),
        .i_third_z    (i_third_z),
        .o_valid      (f_valid),
        .o_nx         (f_nx),
        .o_ny         (f_ny),
        .o_nz         (f_nz),
        .o_degenerate (f_deg)
    );

    tfn_queue #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH),
        .SLACK (FRONT_STAGES)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_nx, f_ny, f_nz, f_deg}),
        .i_pop   (!q_empty),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    tfn_back #(
        .NW               (NW),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_nx         (q_out[QDW-1 -: NW]),
        .i_ny         (q_out[2*NW -: NW]),
        .i_nz         (q_out[NW -: NW]),
        .i_degenerate (q_out[0]),
        .o_valid      (o_strobe),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate)
    );

endmodule
`default_nettype wire

/* hw/rtl/tfn_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module tfn_checker #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_strobe,
    input wire logic [NORMAL_FRAC_BITS+1:0] o_normal_x,
    input wire logic [NORMAL_FRAC_BITS+1:0] o_normal_y,
    input wire logic [NORMAL_FRAC_BITS+1:0] o_normal_z,
    input wire logic                        o_degenerate
);
    import tfn_pkg::*;

    localparam int OW = NORMAL_FRAC_BITS + 2;
    localparam logic signed [OW-1:0] LIM_HI = OW'(1) << NORMAL_FRAC_BITS;
    localparam logic signed [OW-1:0] LIM_LO = -LIM_HI;

    // No result straight after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_strobe)
        else $error("result strobe right after reset");

    // The back part never stalls, so the front is never held off
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // A degenerate triangle gives a zero normal
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_degenerate |->
            (o_normal_x == '0) && (o_normal_y == '0) && (o_normal_z == '0))
        else $error("degenerate result with nonzero normal");

    // A proper normal has some nonzero component
    a_nonzero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_degenerate |->
            (o_normal_x != '0) || (o_normal_y != '0) || (o_normal_z != '0))
        else $error("zero normal without degenerate flag");

    // Components stay within plus and minus one
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |->
            ($signed(o_normal_x) <= LIM_HI) && ($signed(o_normal_x) >= LIM_LO) &&
            ($signed(o_normal_y) <= LIM_HI) && ($signed(o_normal_y) >= LIM_LO) &&
            ($signed(o_normal_z) <= LIM_HI) && ($signed(o_normal_z) >= LIM_LO))
        else $error("normal component out of range");

    logic unused_start;
    assign unused_start = start;

endmodule

bind triangle_face_normal tfn_checker #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tfn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_normal_x   (o_normal_x),
    .o_normal_y   (o_normal_y),
    .o_normal_z   (o_normal_z),
    .o_degenerate (o_degenerate)
);
`default_nettype wire
